@@ rtl/led_pkg.sv @@
// Shared types, constants and helpers for the edit distance core.
`timescale 1ns / 1ps

package led_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W   = 8;
    localparam int ACT_W   = 2;
    localparam int DIST_W  = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // One row of the cost table moving down the chain.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] cost;
        logic [LEN_W-1:0] diag;
    } led_link_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             init;
        logic             wr_en;
        logic [LEN_W-1:0] wr_pos;
        logic [SYM_W-1:0] wr_sym;
        logic [LEN_W-1:0] n_len;
    } led_ctl_t;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
        logic [DIST_W-1:0] r;
        if (int'(v) > int'(DIST_MAX)) begin
            r = DIST_MAX;
        end else begin
            r = DIST_W'(v);
        end
        return r;
    endfunction

endpackage

@@ rtl/levenshtein_edit_distance_core.sv @@
// Top level of the Levenshtein edit distance core: sequencer plus cell chain.
`timescale 1ns / 1ps

// Usage:
//   The input stream carries one item per beat. s_tuser holds the action
//   (0 append s_tdata to the first string, 1 append to the second string,
//   2 compute, 3 ignored) and s_tdata holds the byte. An append leaves s_tready
//   high, so appends can follow back to back. A string holds up to MAX_LEN bytes; further bytes are dropped and
//   flagged. A compute item returns one result on the output stream:
//   m_tdata holds the distance and m_tuser the overflow flag; both strings
//   and the flag are then cleared for the next pair.
//   The second string sits in a chain of MAX_LEN cells, one column each; the
//   first string is read from a small memory and streamed through the chain
//   one row per cycle. A compute streams all rows, then waits for the last
//   row to leave the final cell (the chain length sets the drain time); an
//   empty first string skips both. s_tready is low during a compute.
//   After reset both strings are empty and no result is pending. A result
//   waiting on a stalled m_tready does not block appends; a following compute
//   holds its own result until the output register is free.

module levenshtein_edit_distance_core
    import led_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] symbol
    input  logic [1:0]       s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [6:0] distance, [7] zero
    output logic             m_tuser    // [0] overflow
);

    led_ctl_t  ctl;
    led_link_t links [MAX_LEN + 1];

    led_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .ctl      (ctl),
        .head     (links[0]),
        .tail     (links[MAX_LEN])
    );

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        led_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (LEN_W'(k + 1)),
            .ctl      (ctl),
            .link_in  (links[k]),
            .link_out (links[k + 1])
        );
    end

endmodule

@@ rtl/led_cell.sv @@
// One column cell of the systolic edit distance chain.
`timescale 1ns / 1ps

module led_cell
    import led_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LEN_W-1:0] cell_idx,
    input  led_ctl_t         ctl,
    input  led_link_t        link_in,
    output led_link_t        link_out
);

    logic [SYM_W-1:0] sym_reg;
    logic [LEN_W-1:0] val_reg;
    logic [LEN_W-1:0] val_next;
    logic [LEN_W-1:0] min_ab;
    logic [LEN_W-1:0] min_abc;
    logic             active;
    led_link_t        out_reg;
    led_link_t        out_next;

    assign active = (cell_idx <= ctl.n_len);

    always_comb begin
        min_ab  = (val_reg < link_in.cost) ? val_reg : link_in.cost;
        min_abc = (min_ab < link_in.diag) ? min_ab : link_in.diag;
        if (link_in.sym == sym_reg) begin
            val_next = link_in.diag;
        end else begin
            val_next = min_abc + LEN_W'(1);
        end
    end

    always_comb begin
        out_next       = link_in;
        out_next.valid = link_in.valid && !ctl.init;
        // Columns past the second string pass the row value straight through.
        if (active) begin
            out_next.cost = val_next;
            out_next.diag = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en && (ctl.wr_pos + LEN_W'(1) == cell_idx)) begin
            sym_reg <= ctl.wr_sym;
        end
        if (ctl.init) begin
            val_reg <= cell_idx;
        end else if (link_in.valid && active) begin
            val_reg <= val_next;
        end
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg <= out_next;
        end
    end

    assign link_out = out_reg;

endmodule

@@ rtl/led_ctrl.sv @@
// Sequencer: string loading, first string memory, row feed and result register.
`timescale 1ns / 1ps

module led_ctrl
    import led_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,
    input  logic [ACT_W-1:0] s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output led_ctl_t         ctl,
    output led_link_t        head,
    input  led_link_t        tail
);

    typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_DRAIN, ST_DONE} state_t;

    state_t            state_reg;
    logic [LEN_W-1:0]  first_len_reg;
    logic [LEN_W-1:0]  second_len_reg;
    logic              ovf_reg;
    logic [LEN_W-1:0]  row_reg;
    logic [LEN_W-1:0]  row_next;
    logic [SYM_W-1:0]  a_reg;
    logic              feed_valid_reg;
    logic              feed_last_reg;
    logic [LEN_W-1:0]  feed_cost_reg;
    logic [DIST_W-1:0] dist_pend_reg;
    logic              ovf_pend_reg;
    logic              m_tvalid_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic              m_ovf_reg;
    logic              s_accept;
    logic              app_first;
    logic              app_second;

    logic [SYM_W-1:0]  mem [MAX_LEN];

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign app_first  = s_accept && (s_tuser == ACT_FIRST);
    assign app_second = s_accept && (s_tuser == ACT_SECOND);
    assign row_next   = row_reg + LEN_W'(1);

    always_ff @(posedge aclk) begin
        if (app_first && (int'(first_len_reg) < MAX_LEN)) begin
            mem[first_len_reg[ADDR_W-1:0]] <= s_tdata;
        end
        a_reg <= mem[row_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            feed_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            feed_valid_reg <= (state_reg == ST_FEED);
            // Drop the result on handshake unless a new one loads in this cycle.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    row_reg <= '0;
                    if (app_first) begin
                        if (int'(first_len_reg) < MAX_LEN) begin
                            first_len_reg <= first_len_reg + LEN_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end else if (app_second) begin
                        if (int'(second_len_reg) < MAX_LEN) begin
                            second_len_reg <= second_len_reg + LEN_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end else if (s_accept && (s_tuser == ACT_COMPUTE)) begin
                        if (first_len_reg == '0) begin
                            // Empty first string: the distance is the other length.
                            dist_pend_reg  <= sat_dist(second_len_reg);
                            ovf_pend_reg   <= ovf_reg;
                            first_len_reg  <= '0;
                            second_len_reg <= '0;
                            ovf_reg        <= 1'b0;
                            state_reg      <= ST_DONE;
                        end else begin
                            state_reg <= ST_FEED;
                        end
                    end
                end
                ST_FEED: begin
                    feed_cost_reg  <= row_next;
                    feed_last_reg  <= (row_next == first_len_reg);
                    row_reg        <= row_next;
                    if (row_next == first_len_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // Wait for the last row to leave the final cell.
                    if (tail.valid && tail.last) begin
                        dist_pend_reg  <= sat_dist(tail.cost);
                        ovf_pend_reg   <= ovf_reg;
                        first_len_reg  <= '0;
                        second_len_reg <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_dist_reg   <= dist_pend_reg;
                        m_ovf_reg    <= ovf_pend_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign ctl.init   = s_accept && (s_tuser == ACT_COMPUTE);
    assign ctl.wr_en  = app_second && (int'(second_len_reg) < MAX_LEN);
    assign ctl.wr_pos = second_len_reg;
    assign ctl.wr_sym = s_tdata;
    assign ctl.n_len  = second_len_reg;

    assign head.valid = feed_valid_reg;
    assign head.last  = feed_last_reg;
    assign head.sym   = a_reg;
    assign head.cost  = feed_cost_reg;
    assign head.diag  = feed_cost_reg - LEN_W'(1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - DIST_W){1'b0}}, m_dist_reg};
    assign m_tuser  = m_ovf_reg;

endmodule

@@ rtl/led_chk.sv @@
// Port-level checks for the edit distance core, bound to the top level.
`timescale 1ns / 1ps

module led_chk
    import led_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7] == 1'b0)
        else $error("distance padding bit set");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_COMPUTE) |=> !s_tready)
        else $error("input taken during compute");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind levenshtein_edit_distance_core led_chk u_led_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
